// File: rtl/core/sprite_pixel_shader_core_assert.svh
// Assertion macros for the sprite pixel shader core.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef SPRITE_PIXEL_SHADER_CORE_ASSERT_SVH
`define SPRITE_PIXEL_SHADER_CORE_ASSERT_SVH

// Property checked every clock, off while in reset.
`define SPSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication into the next cycle.
`define SPSC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/spsc_pkg.sv
// Shared types and constants of the sprite pixel shader core.
// No dependencies.
package spsc_pkg;

   localparam int SCREEN_W   = 1024;
   localparam int SCREEN_H   = 768;
   localparam int TEX_W_LOG  = 6;   // TEX_W = 64
   localparam int TEX_H_LOG  = 6;   // TEX_H = 64
   localparam int TEX_ADDR_W = 12;
   localparam int DEPTH_AW   = 10;
   localparam int NUM_W      = 19;  // signed texture-map numerators
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_TEXEL = 2'd0,
      OP_DEPTH = 2'd1,
      OP_SHADE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_START_X = 3'd0,
      CSR_BOX_END_X   = 3'd1,
      CSR_BOX_START_Y = 3'd2,
      CSR_BOX_END_Y   = 3'd3,
      CSR_SIZE        = 3'd4,
      CSR_CENTER_X    = 3'd5,
      CSR_DEPTH       = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic signed [12:0] box_start_x;
      logic signed [12:0] box_end_x;
      logic signed [12:0] box_start_y;
      logic signed [12:0] box_end_y;
      logic        [15:0] sprite_size;
      logic signed [16:0] screen_center_x;
      logic signed [31:0] sprite_depth;
   } cfg_type;

   typedef struct packed {
      logic                    is_tex_wr;
      logic [9:0]              x;
      logic [9:0]              y;
      logic                    pass;
      logic signed [NUM_W-1:0] a;
      logic signed [NUM_W-1:0] b;
      logic [TEX_ADDR_W-1:0]   idx;
      logic [23:0]             rgb;
   } que_entry_type;

   typedef struct packed {
      logic          push;
      que_entry_type data;
   } que_push_type;

   typedef struct packed {
      logic              not_empty;
      logic [QCNT_W-1:0] count;
   } que_stat_type;

endpackage

// File: rtl/core/spsc_if.sv
// Stream interfaces of the sprite pixel shader core: request and response.
// Plain valid/ready channels; no dependencies.
interface spsc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [11:0] texel_index;
   logic [23:0] texel_rgb;
   logic [31:0] column_depth;
   logic [9:0]  pixel_x;
   logic [9:0]  pixel_y;
   modport source (output valid, operation, texel_index, texel_rgb, column_depth,
                   pixel_x, pixel_y, input ready);
   modport sink   (input valid, operation, texel_index, texel_rgb, column_depth,
                   pixel_x, pixel_y, output ready);
endinterface

interface spsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  out_x;
   logic [9:0]  out_y;
   logic [23:0] out_rgb;
   logic        draw;
   modport source (output valid, out_x, out_y, out_rgb, draw, input ready);
   modport sink   (input valid, out_x, out_y, out_rgb, draw, output ready);
endinterface

// File: rtl/core/spsc_front.sv
// Front end: accepts beats, owns the column depth store, runs the box and
// depth tests and forms the texture-map numerators. Uses spsc_pkg, spsc_if.
module spsc_front (
   input  logic                  clock,
   input  logic                  reset,
   spsc_req_if.sink              req_chan,
   input  spsc_pkg::cfg_type     cfg,
   input  spsc_pkg::que_stat_type q_stat,
   output spsc_pkg::que_push_type q_push,
   output logic                  busy
);
   logic                   f0_valid_ff, f0_valid_in;
   logic [1:0]             f0_op_ff;
   logic [11:0]            f0_idx_ff;
   logic [23:0]            f0_rgb_ff;
   logic [9:0]             f0_x_ff;
   logic [9:0]             f0_y_ff;
   logic signed [31:0]     col_depth_ff;
   logic [31:0]            depth_mem [2**spsc_pkg::DEPTH_AW];
   logic                   accept;
   logic [spsc_pkg::QCNT_W:0] used;
   logic signed [13:0]     xs, ys;
   logic                   pass;

   assign used = {1'b0, q_stat.count} + {{spsc_pkg::QCNT_W{1'b0}}, f0_valid_ff};
   assign req_chan.ready = used < (spsc_pkg::QCNT_W+1)'(spsc_pkg::QDEPTH);
   assign accept = req_chan.valid && req_chan.ready;
   assign busy = f0_valid_ff;

   always_comb begin
      case (spsc_pkg::op_type'(req_chan.operation))
         spsc_pkg::OP_TEXEL, spsc_pkg::OP_SHADE: f0_valid_in = accept;
         default: f0_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= f0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f0_op_ff  <= req_chan.operation;
         f0_idx_ff <= req_chan.texel_index;
         f0_rgb_ff <= req_chan.texel_rgb;
         f0_x_ff   <= req_chan.pixel_x;
         f0_y_ff   <= req_chan.pixel_y;
         if (req_chan.operation == spsc_pkg::OP_DEPTH) begin
            depth_mem[req_chan.pixel_x] <= req_chan.column_depth;
         end
         col_depth_ff <= depth_mem[req_chan.pixel_x];
      end
   end

   assign xs = $signed({4'b0, f0_x_ff});
   assign ys = $signed({4'b0, f0_y_ff});

   assign pass = (xs >= 14'(cfg.box_start_x)) && (xs < 14'(cfg.box_end_x))
              && (ys >= 14'(cfg.box_start_y)) && (ys < 14'(cfg.box_end_y))
              && (f0_x_ff != 10'd0)
              && ({2'b0, f0_x_ff} < 13'(spsc_pkg::SCREEN_W))
              && (cfg.sprite_depth > 32'sd0) && (cfg.sprite_depth < col_depth_ff)
              && (cfg.sprite_size != 16'd0);

   always_comb begin
      q_push.push           = f0_valid_ff;
      q_push.data.is_tex_wr = (f0_op_ff == spsc_pkg::OP_TEXEL);
      q_push.data.x         = f0_x_ff;
      q_push.data.y         = f0_y_ff;
      q_push.data.pass      = pass;
      q_push.data.a         = $signed({9'b0, f0_x_ff})
                            + $signed({4'b0, cfg.sprite_size[15:1]})
                            - spsc_pkg::NUM_W'(cfg.screen_center_x);
      q_push.data.b         = $signed({8'b0, f0_y_ff, 1'b0})
                            - spsc_pkg::NUM_W'(spsc_pkg::SCREEN_H)
                            + $signed({3'b0, cfg.sprite_size});
      q_push.data.idx       = f0_idx_ff;
      q_push.data.rgb       = f0_rgb_ff;
   end
endmodule

// File: rtl/core/spsc_queue.sv
// Short register queue between front and back end.
// Uses spsc_pkg types.
module spsc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  spsc_pkg::que_push_type q_push,
   input  logic                   pop,
   output spsc_pkg::que_entry_type head,
   output spsc_pkg::que_stat_type q_stat
);
   spsc_pkg::que_entry_type   slot_ff [spsc_pkg::QDEPTH];
   logic [spsc_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [spsc_pkg::QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push.push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)         rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + spsc_pkg::QCNT_W'(q_push.push)
                              - spsc_pkg::QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) slot_ff[wr_ptr_ff] <= q_push.data;
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign q_stat.count     = count_ff;
   assign q_stat.not_empty = (count_ff != '0);
endmodule

// File: rtl/core/spsc_back.sv
// Back end: texture-coordinate range checks, bit-per-stage dividers by sprite size
// and by twice it, texture store, response register. Uses spsc_pkg, spsc_if.
module spsc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  spsc_pkg::cfg_type       cfg,
   input  spsc_pkg::que_entry_type head,
   input  spsc_pkg::que_stat_type  q_stat,
   output logic                    pop,
   spsc_rsp_if.source              rsp_chan
);
   localparam int TXB = spsc_pkg::TEX_W_LOG;
   localparam int TYB = spsc_pkg::TEX_H_LOG;
   localparam int NST = (TXB > TYB) ? TXB : TYB;

   typedef struct packed {
      logic                  valid;
      logic                  is_tex_wr;
      logic [9:0]            x;
      logic [9:0]            y;
      logic                  ok;
      logic [17:0]           rx;
      logic [17:0]           ry;
      logic [TXB-1:0]        qx;
      logic [TYB-1:0]        qy;
      logic [spsc_pkg::TEX_ADDR_W-1:0] idx;
      logic [23:0]           rgb;
   } bk_stage_type;

   bk_stage_type st_ff [NST+1];
   bk_stage_type st_in [NST+1];
   logic         en;
   logic [23:0]  tex_mem [2**spsc_pkg::TEX_ADDR_W];
   logic [23:0]  tex_rd_ff;
   logic         out_valid_ff, out_ok_ff;
   logic [9:0]   out_x_ff, out_y_ff;
   logic [spsc_pkg::TEX_ADDR_W-1:0] tex_addr;
   logic [16:0]  dx, dy;
   logic [31:0]  neg_a, neg_b;
   logic         a_in, a_low, b_in, b_low;
   logic         draw;

   assign en  = !out_valid_ff || rsp_chan.ready;
   assign pop = en && q_stat.not_empty;
   assign dx  = {1'b0, cfg.sprite_size};
   assign dy  = {cfg.sprite_size, 1'b0};

   // Range tests: a nonnegative numerator below the divisor gives a
   // quotient in range; a small negative one truncates to zero.
   assign neg_a = 32'(-head.a) << TXB;
   assign neg_b = 32'(-head.b) << TYB;
   assign a_in  = !head.a[spsc_pkg::NUM_W-1] && (head.a[17:0] < {1'b0, dx});
   assign a_low =  head.a[spsc_pkg::NUM_W-1] && (neg_a < {16'b0, cfg.sprite_size});
   assign b_in  = !head.b[spsc_pkg::NUM_W-1] && (head.b[17:0] < {1'b0, dy});
   assign b_low =  head.b[spsc_pkg::NUM_W-1] && (neg_b < {15'b0, dy});

   function automatic logic [18:0] div_step(input logic [17:0] r, input logic [16:0] d);
      logic [18:0] r2;
      r2 = {r, 1'b0};
      if (r2 >= {2'b0, d}) begin
         div_step = {1'b1, 18'(r2 - {2'b0, d})};
      end else begin
         div_step = {1'b0, r2[17:0]};
      end
   endfunction

   always_comb begin
      logic [18:0] sx, sy;
      st_in[0].valid     = pop;
      st_in[0].is_tex_wr = head.is_tex_wr;
      st_in[0].x         = head.x;
      st_in[0].y         = head.y;
      st_in[0].ok        = head.pass && (a_in || a_low) && (b_in || b_low);
      st_in[0].rx        = a_in ? head.a[17:0] : 18'd0;
      st_in[0].ry        = b_in ? head.b[17:0] : 18'd0;
      st_in[0].qx        = '0;
      st_in[0].qy        = '0;
      st_in[0].idx       = head.idx;
      st_in[0].rgb       = head.rgb;
      for (int k = 1; k <= NST; k++) begin
         st_in[k] = st_ff[k-1];
         sx = div_step(st_ff[k-1].rx, dx);
         sy = div_step(st_ff[k-1].ry, dy);
         if (k <= TXB) begin
            st_in[k].rx = sx[17:0];
            st_in[k].qx = {st_ff[k-1].qx[TXB-2:0], sx[18]};
         end
         if (k <= TYB) begin
            st_in[k].ry = sy[17:0];
            st_in[k].qy = {st_ff[k-1].qy[TYB-2:0], sy[18]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NST; k++) st_ff[k].valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= NST; k++) st_ff[k] <= st_in[k];
         out_valid_ff <= st_ff[NST].valid && !st_ff[NST].is_tex_wr;
      end
   end

   assign tex_addr = st_ff[NST].is_tex_wr ? st_ff[NST].idx
                   : spsc_pkg::TEX_ADDR_W'({st_ff[NST].qy, st_ff[NST].qx});

   always_ff @(posedge clock) begin
      if (en) begin
         if (st_ff[NST].valid && st_ff[NST].is_tex_wr) begin
            tex_mem[tex_addr] <= st_ff[NST].rgb;
         end
         tex_rd_ff <= tex_mem[tex_addr];
         out_x_ff  <= st_ff[NST].x;
         out_y_ff  <= st_ff[NST].y;
         out_ok_ff <= st_ff[NST].ok;
      end
   end

   assign draw             = out_ok_ff && (tex_rd_ff != 24'd0);
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.out_x   = out_x_ff;
   assign rsp_chan.out_y   = out_y_ff;
   assign rsp_chan.draw    = draw;
   assign rsp_chan.out_rgb = draw ? tex_rd_ff : 24'd0;
endmodule

// File: rtl/core/sprite_pixel_shader_core.sv
// Top level of the sprite pixel shader core: config registers, front end,
// queue and back end. Uses spsc_pkg, spsc_if and the assertion header.
//
// Takes one beat per cycle while the queue has room: texel loads, column depth
// loads and shade beats in any mix. A shade beat yields one response beat after
// the front register, the queue, one stage per texture-coordinate bit of the
// restoring dividers by sprite size and the texture store read. Loads yield
// nothing. Texel writes take effect in the texture-store stage and depth writes
// in the front stage, so every read sees all earlier loads. A response that
// waits stalls the back end; the four-entry queue keeps the front accepting
// until it fills. Config writes belong in idle periods.
`include "sprite_pixel_shader_core_assert.svh"

module sprite_pixel_shader_core (
   input  logic                              clock,
   input  logic                              reset,
   spsc_req_if.sink                          req_chan,
   spsc_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [spsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   spsc_pkg::cfg_type       cfg_ff;
   spsc_pkg::que_push_type  q_push;
   spsc_pkg::que_stat_type  q_stat;
   spsc_pkg::que_entry_type head;
   logic                    pop;
   logic                    front_busy;

   // config registers, values truncated to their field widths
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_start_x     <= '0;
         cfg_ff.box_end_x       <= '0;
         cfg_ff.box_start_y     <= '0;
         cfg_ff.box_end_y       <= '0;
         cfg_ff.sprite_size     <= 16'd1;
         cfg_ff.screen_center_x <= '0;
         cfg_ff.sprite_depth    <= '0;
      end else if (csr_wr_en) begin
         case (spsc_pkg::csr_idx_type'(csr_index))
            spsc_pkg::CSR_BOX_START_X: cfg_ff.box_start_x     <= csr_wdata[12:0];
            spsc_pkg::CSR_BOX_END_X:   cfg_ff.box_end_x       <= csr_wdata[12:0];
            spsc_pkg::CSR_BOX_START_Y: cfg_ff.box_start_y     <= csr_wdata[12:0];
            spsc_pkg::CSR_BOX_END_Y:   cfg_ff.box_end_y       <= csr_wdata[12:0];
            spsc_pkg::CSR_SIZE:        cfg_ff.sprite_size     <= csr_wdata[15:0];
            spsc_pkg::CSR_CENTER_X:    cfg_ff.screen_center_x <= csr_wdata[16:0];
            spsc_pkg::CSR_DEPTH:       cfg_ff.sprite_depth    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   spsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .busy     (front_busy)
   );

   spsc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   spsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // queue credit: a push into a full queue would lose a beat
   `SPSC_ASSERT(a_no_overflow, clock, reset, !(q_push.push && !pop && q_stat.count == 3'(spsc_pkg::QDEPTH)), "queue overflow")
   // front register plus queue never exceed the queue depth
   `SPSC_ASSERT(a_credit, clock, reset, ({1'b0, q_stat.count} + {3'b0, front_busy}) <= 4'(spsc_pkg::QDEPTH), "credit exceeded")
   // a push without a pop leaves the queue non-empty in the cycle after
   `SPSC_ASSERT_NEXT(a_pop_fill, clock, reset, q_push.push && !pop, q_stat.not_empty, "queue lost an entry")
   // a suppressed pixel carries black
   `SPSC_ASSERT(a_rgb_key, clock, reset, !rsp_chan.valid || rsp_chan.draw || rsp_chan.out_rgb == 24'd0, "color on undrawn pixel")
endmodule

// File: verif/sprite_pixel_shader_core_tb.sv
// Self-checking testbench of sprite_pixel_shader_core: directed table, then random phases.
// Depends on spsc_pkg, spsc_req_if / spsc_rsp_if and the core; checks every response beat.
module sprite_pixel_shader_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored by the core
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;          // covers the pipe plus the four-deep queue, with margin
   localparam int RANDOM_BEATS = 1500;

   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_type;

   // one directed row: either a register write or a request beat
   typedef struct {
      row_kind_type          kind;
      spsc_pkg::csr_idx_type reg_idx;
      logic [31:0]           reg_val;
      logic [1:0]            op;
      logic [11:0]           tidx;
      logic [23:0]           trgb;
      logic [31:0]           cdepth;
      logic [9:0]            px;
      logic [9:0]            py;
      bit                    typed;     // expectation typed in below, not predicted
      logic                  t_draw;
      logic [23:0]           t_rgb;
   } stim_row_type;

   typedef struct packed {
      logic [9:0]  x;
      logic [9:0]  y;
      logic [23:0] rgb;
      logic        draw;
   } pixel_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [spsc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [spsc_pkg::CSR_DATA_W-1:0] csr_wdata;

   spsc_req_if req ();
   spsc_rsp_if rsp ();

   sprite_pixel_shader_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the core's registers and stores
   spsc_pkg::cfg_type  shadow_cfg;
   logic [23:0]        texel_mem [4096];
   bit                 texel_set [4096];
   logic signed [31:0] wall_depth [1024];
   bit                 wall_set [1024];

   pixel_type pending_pixels [$];
   int        errors = 0;
   bit        burst_mode = 0;   // no idling on the request side while set

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Pixel prediction. Returns whether the texture store gets read, and where, so the
   // caller can make sure that entry was loaded first.
   function automatic void shade_pixel(input logic [9:0] x, input logic [9:0] y,
                                       output pixel_type px, output bit tex_rd,
                                       output logic [11:0] tex_addr);
      longint sx, sy, sz, ctr, tx, ty;
      sx = longint'(x);
      sy = longint'(y);
      sz = longint'(shadow_cfg.sprite_size);
      ctr = longint'($signed(shadow_cfg.screen_center_x));
      px = '{x: x, y: y, rgb: 24'h0, draw: 1'b0};
      tex_rd = 0;
      tex_addr = '0;
      if (sx >= longint'($signed(shadow_cfg.box_start_x)) &&
          sx <  longint'($signed(shadow_cfg.box_end_x)) &&
          sy >= longint'($signed(shadow_cfg.box_start_y)) &&
          sy <  longint'($signed(shadow_cfg.box_end_y)) &&
          sx > 0 && sx < spsc_pkg::SCREEN_W &&
          $signed(shadow_cfg.sprite_depth) > 0 &&
          $signed(shadow_cfg.sprite_depth) < wall_depth[x] && sz != 0) begin
         tx = ((sx + sz / 2 - ctr) * 64) / sz;               // truncates toward zero
         ty = ((2 * sy - spsc_pkg::SCREEN_H + sz) * 64) / (2 * sz);
         if (tx >= 0 && tx < 64 && ty >= 0 && ty < 64) begin
            tex_rd = 1;
            tex_addr = 12'(ty * 64 + tx);
            if (texel_mem[tex_addr] != 24'h0) begin
               px.draw = 1'b1;
               px.rgb = texel_mem[tex_addr];
            end
         end
      end
   endfunction

   // Drive one request beat. Stores are updated here for loads.
   task automatic put_beat(input logic [1:0] op, input logic [11:0] tidx,
                           input logic [23:0] trgb, input logic [31:0] cdepth,
                           input logic [9:0] px, input logic [9:0] py);
      int gap;
      gap = burst_mode ? 0 : int'($urandom_range(0, 10));
      if (op == spsc_pkg::OP_TEXEL) begin
         texel_mem[tidx] = trgb;
         texel_set[tidx] = 1;
      end else if (op == spsc_pkg::OP_DEPTH) begin
         wall_depth[px] = cdepth;
         wall_set[px] = 1;
      end
      repeat (gap) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.operation = op;
      req.texel_index = tidx;
      req.texel_rgb = trgb;
      req.column_depth = cdepth;
      req.pixel_x = px;
      req.pixel_y = py;
      req.valid = 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_wall_depth();
      longint d;
      if ($urandom_range(0, 4) == 0) return $urandom;
      d = longint'($signed(shadow_cfg.sprite_depth)) + longint'($urandom_range(1, 1 << 20));
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      return 32'(d);
   endfunction

   // A shade beat first gets any store entry it would read loaded.
   task automatic issue(input logic [1:0] op, input logic [11:0] tidx,
                        input logic [23:0] trgb, input logic [31:0] cdepth,
                        input logic [9:0] px, input logic [9:0] py,
                        input bit typed, input logic t_draw, input logic [23:0] t_rgb);
      pixel_type   want;
      bit          tex_rd;
      logic [11:0] tex_addr;
      if (op == spsc_pkg::OP_SHADE) begin
         if (!wall_set[px])
            put_beat(spsc_pkg::OP_DEPTH, 12'($urandom), 24'($urandom), pick_wall_depth(),
                     px, 10'($urandom));
         shade_pixel(px, py, want, tex_rd, tex_addr);
         if (tex_rd && !texel_set[tex_addr]) begin
            put_beat(spsc_pkg::OP_TEXEL, tex_addr,
                     ($urandom_range(0, 5) == 0) ? 24'h0 : 24'($urandom),
                     $urandom, 10'($urandom), 10'($urandom));
            shade_pixel(px, py, want, tex_rd, tex_addr);
         end
         if (typed) want = '{x: px, y: py, rgb: t_rgb, draw: t_draw};
         pending_pixels.push_back(want);
      end
      put_beat(op, tidx, trgb, cdepth, px, py);
   endtask

   // Pressure point too: the sender holds here until every response is back.
   task automatic wait_idle();
      req.valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input spsc_pkg::csr_idx_type idx, input logic [31:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         spsc_pkg::CSR_BOX_START_X: shadow_cfg.box_start_x = val[12:0];
         spsc_pkg::CSR_BOX_END_X:   shadow_cfg.box_end_x = val[12:0];
         spsc_pkg::CSR_BOX_START_Y: shadow_cfg.box_start_y = val[12:0];
         spsc_pkg::CSR_BOX_END_Y:   shadow_cfg.box_end_y = val[12:0];
         spsc_pkg::CSR_SIZE:        shadow_cfg.sprite_size = val[15:0];
         spsc_pkg::CSR_CENTER_X:    shadow_cfg.screen_center_x = val[16:0];
         spsc_pkg::CSR_DEPTH:       shadow_cfg.sprite_depth = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // New sprite setup for one random phase; profile picks the flavor.
   task automatic setup_sprite(input int profile);
      int sz, ctr;
      sz = int'($urandom_range(2, 700));
      ctr = int'($urandom_range(0, 1023));
      wait_idle();
      case (profile)
         0: begin   // ordinary sprite, box hugging it
            write_reg(spsc_pkg::CSR_BOX_START_X,
                      32'(ctr - sz / 2 - int'($urandom_range(0, 3))));
            write_reg(spsc_pkg::CSR_BOX_END_X,
                      32'(ctr + sz / 2 + int'($urandom_range(0, 3))));
            write_reg(spsc_pkg::CSR_BOX_START_Y, 32'(384 - sz / 2));
            write_reg(spsc_pkg::CSR_BOX_END_Y, 32'(384 + sz / 2 + 1));
            write_reg(spsc_pkg::CSR_SIZE, 32'(sz));
            write_reg(spsc_pkg::CSR_CENTER_X, 32'(ctr));
            write_reg(spsc_pkg::CSR_DEPTH, $urandom_range(1, 1 << 24));
         end
         1: begin   // register extremes
            write_reg(spsc_pkg::CSR_BOX_START_X, -32'sd4096);
            write_reg(spsc_pkg::CSR_BOX_END_X, 32'd4095);
            write_reg(spsc_pkg::CSR_BOX_START_Y, -32'sd4096);
            write_reg(spsc_pkg::CSR_BOX_END_Y, 32'd4095);
            write_reg(spsc_pkg::CSR_SIZE, $urandom_range(0, 1) ? 32'd65535 : 32'd1);
            case ($urandom_range(0, 2))
               0: write_reg(spsc_pkg::CSR_CENTER_X, -32'sd65536);
               1: write_reg(spsc_pkg::CSR_CENTER_X, 32'd65535);
               default: write_reg(spsc_pkg::CSR_CENTER_X, 32'(ctr));
            endcase
            write_reg(spsc_pkg::CSR_DEPTH, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd1);
         end
         2: begin   // sprite behind the camera or zero size
            write_reg(spsc_pkg::CSR_BOX_START_X, 32'd0);
            write_reg(spsc_pkg::CSR_BOX_END_X, 32'd1024);
            write_reg(spsc_pkg::CSR_BOX_START_Y, 32'd0);
            write_reg(spsc_pkg::CSR_BOX_END_Y, 32'd768);
            write_reg(spsc_pkg::CSR_SIZE, $urandom_range(0, 1) ? 32'd0 : 32'(sz));
            write_reg(spsc_pkg::CSR_CENTER_X, 32'(ctr));
            write_reg(spsc_pkg::CSR_DEPTH, $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0);
         end
         default: begin   // anything goes
            write_reg(spsc_pkg::CSR_BOX_START_X, $urandom);
            write_reg(spsc_pkg::CSR_BOX_END_X, $urandom);
            write_reg(spsc_pkg::CSR_BOX_START_Y, $urandom);
            write_reg(spsc_pkg::CSR_BOX_END_Y, $urandom);
            write_reg(spsc_pkg::CSR_SIZE, $urandom);
            write_reg(spsc_pkg::CSR_CENTER_X, $urandom);
            write_reg(spsc_pkg::CSR_DEPTH, $urandom);
         end
      endcase
   endtask

   // Response side: random stalls, compare each beat against the oldest expectation.
   initial begin
      int stall;
      pixel_type want;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = (burst_mode || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
         repeat (stall) begin
            rsp.ready = 1'b0;
            @(negedge clock);
         end
         rsp.ready = 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         if (pending_pixels.size() == 0) begin
            $error("response beat with nothing expected: x=%0d y=%0d", rsp.out_x, rsp.out_y);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp.out_x !== want.x) begin
               $error("out_x expected %0d actual %0d", want.x, rsp.out_x);
               errors++;
            end
            if (rsp.out_y !== want.y) begin
               $error("out_y expected %0d actual %0d", want.y, rsp.out_y);
               errors++;
            end
            if (rsp.out_rgb !== want.rgb) begin
               $error("out_rgb expected %06h actual %06h", want.rgb, rsp.out_rgb);
               errors++;
            end
            if (rsp.draw !== want.draw) begin
               $error("draw expected %0b actual %0b", want.draw, rsp.draw);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // Directed table. Typed expectations: reset config draws nothing; the sprite
   // centered at (512,384) with size 64 maps pixel (512,384) to texel 2080.
   stim_row_type directed [] = '{
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_DEPTH, 0, 0, 32'h7FFF_FFFF,
        0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_DEPTH, 12'hFFF, 24'hFF_FFFF,
        32'h8000_0000, 1023, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 0, 0, 1, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 1023, 1023, 1, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, OP_UNUSED, 12'hFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
        1023, 1023, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_TEXEL, 12'hFFF, 24'hFF_FFFF, 0,
        0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_TEXEL, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_BOX_START_X, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_BOX_END_X, 1024, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_BOX_START_Y, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_BOX_END_Y, 768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_SIZE, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_CENTER_X, 512, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_DEPTH, 32'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_TEXEL, 2080, 24'h12_3456, 0,
        0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_DEPTH, 0, 0, 32'h2_0000,
        512, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 512, 384,
        1, 1, 24'h12_3456},
      // transparent texel
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_TEXEL, 2081, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_DEPTH, 0, 0, 32'h2_0000,
        513, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 513, 384, 1, 0, 0},
      // wall at the same depth hides the sprite
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_TEXEL, 2082, 1, 0, 0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_DEPTH, 0, 0, 32'h1_0000,
        514, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 514, 384, 1, 0, 0},
      // texture coordinate off the texture
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 600, 384, 1, 0, 0},
      // zero size, then a sprite behind the camera
      '{ROW_CSR, spsc_pkg::CSR_SIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 512, 384, 1, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_SIZE, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, spsc_pkg::CSR_DEPTH, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_BEAT, spsc_pkg::CSR_SIZE, 0, spsc_pkg::OP_SHADE, 0, 0, 0, 512, 384, 1, 0, 0}
   };

   initial begin
      int sent, phase_left, sz;
      longint ctr, sx, sy;
      logic [1:0] op;
      shadow_cfg = '{box_start_x: 0, box_end_x: 0, box_start_y: 0, box_end_y: 0,
                     sprite_size: 1, screen_center_x: 0, sprite_depth: 0};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.operation = spsc_pkg::OP_TEXEL;
      req.texel_index = '0;
      req.texel_rgb = '0;
      req.column_depth = '0;
      req.pixel_x = '0;
      req.pixel_y = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            wait_idle();
            write_reg(directed[i].reg_idx, directed[i].reg_val);
         end else begin
            issue(directed[i].op, directed[i].tidx, directed[i].trgb, directed[i].cdepth,
                  directed[i].px, directed[i].py, directed[i].typed,
                  directed[i].t_draw, directed[i].t_rgb);
         end
      end

      // random phases; ignored beats do not count
      sent = 0;
      phase_left = 0;
      while (sent < RANDOM_BEATS) begin
         if (phase_left == 0) begin
            setup_sprite($urandom_range(0, 9) < 6 ? 0 : int'($urandom_range(1, 3)));
            phase_left = int'($urandom_range(120, 220));
         end
         if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
         sz = int'(shadow_cfg.sprite_size);
         ctr = longint'($signed(shadow_cfg.screen_center_x));
         case ($urandom_range(0, 19))
            0, 1: issue(spsc_pkg::OP_TEXEL, 12'($urandom),
                        ($urandom_range(0, 4) == 0) ? 24'h0 : 24'($urandom),
                        $urandom, 10'($urandom), 10'($urandom), 0, 0, 0);
            2, 3: begin
               op = spsc_pkg::OP_DEPTH;
               issue(op, 12'($urandom), 24'($urandom), pick_wall_depth(), 10'($urandom),
                     10'($urandom), 0, 0, 0);
            end
            4: begin
               issue(OP_UNUSED, 12'($urandom), 24'($urandom), $urandom, 10'($urandom),
                     10'($urandom), 0, 0, 0);
               continue;
            end
            5, 6, 7, 8: issue(spsc_pkg::OP_SHADE, 12'($urandom), 24'($urandom), $urandom,
                              10'($urandom), 10'($urandom), 0, 0, 0);
            default: begin   // pixel on or near the sprite
               sx = ctr + longint'($urandom_range(0, sz + 2)) - sz / 2 - 1;
               sy = 384 + longint'($urandom_range(0, sz + 2)) - sz / 2 - 1;
               if (sx < 0 || sx > 1023) sx = longint'($urandom_range(0, 1023));
               if (sy < 0 || sy > 1023) sy = longint'($urandom_range(0, 1023));
               issue(spsc_pkg::OP_SHADE, 12'($urandom), 24'($urandom), $urandom,
                     10'(sx), 10'(sy), 0, 0, 0);
            end
         endcase
         sent++;
         phase_left--;
      end

      burst_mode = 0;
      wait_idle();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
